// File: hdl/bully_pkg.sv
// Shared types and constants for the bully leader election node.
package bully_pkg;

    // Node count of the system; only nodes below this and below 16 are examined.
    localparam int NODES      = 16;
    localparam int ID_W       = 4;
    localparam int MASK_W     = 16;
    localparam int ROUND_W    = 8;
    localparam int KIND_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Reset value of the round limit.
    localparam logic [ROUND_W-1:0] ROUND_LIMIT_RST = 8'd10;

    // Depth of the job queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_ID     = 2'd0,
        CFG_NBR_MASK    = 2'd1,
        CFG_ROUND_LIMIT = 2'd2
    } t_cfg_idx;

    typedef enum logic [KIND_W-1:0] {
        MSG_INIT       = 3'd0,
        MSG_ELECTION   = 3'd1,
        MSG_ALIVE      = 3'd2,
        MSG_DELAY_REQ  = 3'd3,
        MSG_DELAY_RESP = 3'd4,
        MSG_COORD      = 3'd5
    } t_msg_kind;

    typedef enum logic [KIND_W-1:0] {
        SEND_ALIVE      = 3'd0,
        SEND_ELECTION   = 3'd1,
        SEND_DELAY_REQ  = 3'd2,
        SEND_DELAY_RESP = 3'd3,
        SEND_COORD      = 3'd4
    } t_send_kind;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FIRST,
        BK_SCAN,
        BK_TAIL
    } t_back_state;

    // One classified item: an optional first send, a sweep over a set of
    // destinations, an optional final send, and the state seen after the item.
    typedef struct packed {
        logic              first_en;
        t_send_kind        first_kind;
        logic [ID_W-1:0]   first_dest;
        logic [MASK_W-1:0] scan_mask;
        t_send_kind        scan_kind;
        logic              tail_en;
        t_send_kind        tail_kind;
        logic [ID_W-1:0]   tail_dest;
        logic [ID_W-1:0]   leader;
        logic              done;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// File: hdl/bully_fifo.sv
// Short job queue that decouples the classifying front from the sending back.
module bully_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  bully_pkg::t_job     i_job,
    input  logic                i_pop,
    output bully_pkg::t_job     o_job,
    output bully_pkg::t_q_status o_status
);
    import bully_pkg::*;

    t_job                 r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wptr;
    logic [Q_PTR_W-1:0]   r_rptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic                 w_push;
    logic                 w_pop;

    assign o_status.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;
    assign o_job  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

// File: hdl/bully_front.sv
// Front end: configuration registers, election state and item classification.
module bully_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bully_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bully_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_accept,
    input  logic [bully_pkg::KIND_W-1:0]    i_msg_kind,
    input  logic [bully_pkg::ID_W-1:0]      i_sender,
    output logic                            o_push,
    output bully_pkg::t_job                 o_job
);
    import bully_pkg::*;

    logic [ID_W-1:0]    r_node_id;
    logic [MASK_W-1:0]  r_nbr_mask;
    logic [ROUND_W-1:0] r_round_limit;
    logic               r_started;
    logic               r_finished;
    logic [ROUND_W-1:0] r_rounds;
    logic [ID_W-1:0]    r_leader;

    logic               n_started;
    logic               n_finished;
    logic [ROUND_W-1:0] n_rounds;
    logic [ID_W-1:0]    n_leader;

    logic [MASK_W-1:0]  w_range;
    logic [MASK_W-1:0]  w_above;
    t_job               w_job;

    // Nodes that exist, and nodes numbered above this one.
    always_comb begin
        for (int i = 0; i < MASK_W; i++) begin
            w_range[i] = (i < NODES);
            w_above[i] = (ID_W'(i) > r_node_id);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id     <= '0;
            r_nbr_mask    <= '0;
            r_round_limit <= ROUND_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_NODE_ID:     r_node_id     <= i_cfg_data[ID_W-1:0];
                CFG_NBR_MASK:    r_nbr_mask    <= i_cfg_data[MASK_W-1:0];
                CFG_ROUND_LIMIT: r_round_limit <= i_cfg_data[ROUND_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_started  = r_started;
        n_finished = r_finished;
        n_rounds   = r_rounds;
        n_leader   = r_leader;
        w_job      = '0;
        w_job.first_kind = SEND_ALIVE;
        w_job.scan_kind  = SEND_ELECTION;
        w_job.tail_kind  = SEND_DELAY_REQ;
        case (t_msg_kind'(i_msg_kind))
            MSG_INIT, MSG_ELECTION: begin
                w_job.first_en   = (t_msg_kind'(i_msg_kind) == MSG_ELECTION);
                w_job.first_dest = i_sender;
                if (!r_started) begin
                    n_started = 1'b1;
                    if (i_sender < r_node_id) begin
                        w_job.scan_mask = r_nbr_mask & w_range & w_above;
                        w_job.tail_en   = 1'b1;
                        w_job.tail_dest = r_node_id;
                    end
                end
            end
            MSG_ALIVE: begin
                n_finished = 1'b1;
            end
            MSG_DELAY_REQ: begin
                w_job.tail_en   = 1'b1;
                w_job.tail_kind = SEND_DELAY_RESP;
                w_job.tail_dest = i_sender;
            end
            MSG_DELAY_RESP: begin
                if (r_started && !r_finished) begin
                    if (r_rounds < r_round_limit) begin
                        n_rounds        = r_rounds + 1'b1;
                        w_job.tail_en   = 1'b1;
                        w_job.tail_dest = r_node_id;
                    end else begin
                        n_finished      = 1'b1;
                        n_leader        = r_node_id;
                        w_job.scan_mask = r_nbr_mask & w_range;
                        w_job.scan_kind = SEND_COORD;
                    end
                end
            end
            MSG_COORD: begin
                n_leader   = i_sender;
                n_finished = 1'b1;
            end
            default: ;
        endcase
        w_job.leader = n_leader;
        w_job.done   = n_finished;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started  <= 1'b0;
            r_finished <= 1'b0;
            r_rounds   <= '0;
            r_leader   <= '0;
        end else if (i_accept) begin
            r_started  <= n_started;
            r_finished <= n_finished;
            r_rounds   <= n_rounds;
            r_leader   <= n_leader;
        end
    end

    assign o_job  = w_job;
    assign o_push = i_accept && (w_job.first_en || (|w_job.scan_mask) || w_job.tail_en);

endmodule

// File: hdl/bully_back.sv
// Back end: walks one queued job and issues its sends into the output register.
module bully_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bully_pkg::t_job              i_job,
    input  bully_pkg::t_q_status         i_q_status,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [bully_pkg::KIND_W-1:0] o_send_kind,
    output logic [bully_pkg::ID_W-1:0]   o_dest,
    output logic                         o_last,
    output logic [bully_pkg::ID_W-1:0]   o_leader,
    output logic                         o_done_res
);
    import bully_pkg::*;

    t_back_state        r_state;
    t_back_state        n_state;
    t_job               r_job;
    logic [MASK_W-1:0]  r_mask;
    logic [MASK_W-1:0]  n_mask;
    logic               w_load;
    logic               w_emit;
    logic               w_out_free;
    logic [MASK_W-1:0]  w_rest;
    logic [ID_W-1:0]    w_low;

    logic               r_out_valid;
    t_send_kind         r_kind;
    logic [ID_W-1:0]    r_dest;
    logic               r_last;
    logic [ID_W-1:0]    r_leader;
    logic               r_done;
    t_send_kind         n_kind;
    logic [ID_W-1:0]    n_dest;
    logic               n_last;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_rest     = r_mask & (r_mask - 1'b1);

    // Lowest remaining destination.
    always_comb begin
        w_low = '0;
        for (int i = MASK_W - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                w_low = ID_W'(i);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_mask  = r_mask;
        w_load  = 1'b0;
        w_emit  = 1'b0;
        n_kind  = SEND_ALIVE;
        n_dest  = '0;
        n_last  = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_status.empty) begin
                    w_load = 1'b1;
                    n_mask = i_job.scan_mask;
                    if (i_job.first_en) begin
                        n_state = BK_FIRST;
                    end else if (|i_job.scan_mask) begin
                        n_state = BK_SCAN;
                    end else begin
                        n_state = BK_TAIL;
                    end
                end
            end
            BK_FIRST: begin
                n_kind = r_job.first_kind;
                n_dest = r_job.first_dest;
                n_last = (r_mask == '0) && !r_job.tail_en;
                if (w_out_free) begin
                    w_emit = 1'b1;
                    if (|r_mask) begin
                        n_state = BK_SCAN;
                    end else if (r_job.tail_en) begin
                        n_state = BK_TAIL;
                    end else begin
                        n_state = BK_IDLE;
                    end
                end
            end
            BK_SCAN: begin
                n_kind = r_job.scan_kind;
                n_dest = w_low;
                n_last = (w_rest == '0) && !r_job.tail_en;
                if (w_out_free) begin
                    w_emit = 1'b1;
                    n_mask = w_rest;
                    if (|w_rest) begin
                        n_state = BK_SCAN;
                    end else if (r_job.tail_en) begin
                        n_state = BK_TAIL;
                    end else begin
                        n_state = BK_IDLE;
                    end
                end
            end
            BK_TAIL: begin
                n_kind = r_job.tail_kind;
                n_dest = r_job.tail_dest;
                n_last = 1'b1;
                if (w_out_free) begin
                    w_emit  = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The leader and finished flag travel with each send, so a new job loaded
    // while the previous send still waits does not disturb it.
    always_ff @(posedge i_clk) begin
        r_mask <= n_mask;
        if (w_load) begin
            r_job <= i_job;
        end
        if (w_emit) begin
            r_kind   <= n_kind;
            r_dest   <= n_dest;
            r_last   <= n_last;
            r_leader <= r_job.leader;
            r_done   <= r_job.done;
        end
    end

    assign o_pop       = w_load;
    assign o_valid     = r_out_valid;
    assign o_send_kind = r_kind;
    assign o_dest      = r_dest;
    assign o_last      = r_last;
    assign o_leader    = r_leader;
    assign o_done_res  = r_done;

endmodule

// File: hdl/bully_leader_election_node_unit.sv
// Top level of one bully leader election node: front, job queue and back.
//
// Each received message item (kind, sender) is taken by the front, which
// updates the node's election state at once and turns the item into a job
// describing the messages to send; items that send nothing leave no job. The
// front accepts one item per cycle for as long as the two-entry job queue has
// room, so it keeps taking items while earlier sends are still going out. The
// back takes one job from the queue while idle and then issues one send per
// cycle into the output register whenever that register is free or being
// taken, and it loads no new job until the last send of the current one has
// been issued. The back's one-send-per-cycle sequencer sets the sustained
// rate. Every send of an item carries the leader and finished flag as they
// stood after that item, and the final send of an item is marked with last.
// Configuration registers (node_id, neighbor_mask, round_limit) are written
// through a plain write port and should only be changed while the node is idle.
module bully_leader_election_node_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [bully_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bully_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [bully_pkg::KIND_W-1:0]     i_msg_kind,
    input  logic [bully_pkg::ID_W-1:0]       i_sender,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [bully_pkg::KIND_W-1:0]     o_send_kind,
    output logic [bully_pkg::ID_W-1:0]       o_dest,
    output logic                             o_last,
    output logic [bully_pkg::ID_W-1:0]       o_leader,
    output logic                             o_done_res
);
    import bully_pkg::*;

    logic      w_accept;
    logic      w_push;
    logic      w_pop;
    t_job      w_front_job;
    t_job      w_q_job;
    t_q_status w_q_status;

    // An item is only taken when its job is sure to fit in the queue.
    assign o_in_ready = !w_q_status.full;
    assign w_accept   = i_in_valid && o_in_ready;

    bully_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (w_accept),
        .i_msg_kind (i_msg_kind),
        .i_sender   (i_sender),
        .o_push     (w_push),
        .o_job      (w_front_job)
    );

    bully_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_front_job),
        .i_pop    (w_pop),
        .o_job    (w_q_job),
        .o_status (w_q_status)
    );

    bully_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_q_job),
        .i_q_status  (w_q_status),
        .o_pop       (w_pop),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_send_kind (o_send_kind),
        .o_dest      (o_dest),
        .o_last      (o_last),
        .o_leader    (o_leader),
        .o_done_res  (o_done_res)
    );

endmodule

// File: hdl/bully_checker.sv
// Port-level checks for the bully election node, bound to the top level.
module bully_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic [bully_pkg::KIND_W-1:0]     o_send_kind,
    input logic [bully_pkg::ID_W-1:0]       o_dest,
    input logic                             o_last,
    input logic [bully_pkg::ID_W-1:0]       o_leader,
    input logic                             o_done_res
);
    import bully_pkg::*;

    // A pending result item is held until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output item dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_send_kind) && $stable(o_dest) && $stable(o_last)
            && $stable(o_leader) && $stable(o_done_res))
        else $error("output item changed while stalled");

    // Reset leaves no result item pending.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Only defined send kinds leave the node.
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_send_kind == SEND_ALIVE || o_send_kind == SEND_ELECTION
            || o_send_kind == SEND_DELAY_REQ || o_send_kind == SEND_DELAY_RESP
            || o_send_kind == SEND_COORD))
        else $error("undefined send kind on output");

    // A coordinator announcement comes only once the election has finished.
    a_coord_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_send_kind == SEND_COORD |-> o_done_res)
        else $error("coordinator sent before the election finished");

endmodule

bind bully_leader_election_node_unit bully_checker u_bully_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_send_kind (o_send_kind),
    .o_dest      (o_dest),
    .o_last      (o_last),
    .o_leader    (o_leader),
    .o_done_res  (o_done_res)
);
